// ===== rtl/core/ilmt_pkg.sv =====
// ilmt_pkg: shared constants and types of the identifier-to-locator table.
// Used by ilmt_ctrl, id_locator_mapping_table and the testbench; depends on nothing.
package ilmt_pkg;

	localparam int TABLE_ENTRIES   = 256;
	localparam int SLOTS_PER_ENTRY = 3;
	localparam int ENTRY_W         = $clog2(TABLE_ENTRIES);
	localparam int SLOT_DEPTH      = TABLE_ENTRIES * SLOTS_PER_ENTRY;
	localparam int SLOT_AW         = $clog2(SLOT_DEPTH);

	localparam int KEY_W  = 160;
	localparam int ADDR_W = 64;
	localparam int PORT_W = 16;
	localparam int CNT_W  = 2;
	localparam int SIDX_W = 2;

	localparam int S_TDATA_W = 304;
	localparam int M_TDATA_W = 296;

	localparam logic [PORT_W-1:0] REPLY_PORT_RST = 16'd100;

	localparam logic REQ_LOOKUP   = 1'b0;
	localparam logic REQ_REGISTER = 1'b1;

	typedef struct packed {
		logic [ADDR_W-1:0] addr_high;
		logic [ADDR_W-1:0] addr_low;
		logic [PORT_W-1:0] port;
	} locator_t;

	typedef struct packed {
		logic              req_type;
		logic [KEY_W-1:0]  key;
		locator_t          sender;
	} item_t;

	typedef struct packed {
		locator_t          dest;
		logic [CNT_W-1:0]  locator_count;
		logic [SIDX_W-1:0] slot_index;
		locator_t          loc;
		logic              last;
	} result_t;

	typedef struct packed {
		logic [CNT_W-1:0] count;
		logic [KEY_W-1:0] key;
	} key_word_t;

endpackage

// ===== rtl/core/ilmt_ram.sv =====
// ilmt_ram: generic simple dual-port RAM, one write and one registered read port.
// Standalone; instantiated by ilmt_ctrl for the key and locator stores.
module ilmt_ram #(
	parameter int DEPTH = 256,
	parameter int WIDTH = 8
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== rtl/core/ilmt_ctrl.sv =====
// ilmt_ctrl: scan/update sequencer, entry valid bits, key and locator RAMs,
// and the result output register. Depends on ilmt_pkg and ilmt_ram.
module ilmt_ctrl
	import ilmt_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  item_t             in_item,
	input  logic [PORT_W-1:0] reply_port,
	output logic              out_valid,
	input  logic              out_ready,
	output result_t           out_res
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_DECIDE,
		ST_RD,
		ST_LD
	} state_t;

	state_t                   state_q;
	item_t                    item_q;
	logic [TABLE_ENTRIES-1:0] valid_q;
	logic [ENTRY_W-1:0]       scan_idx_q;
	logic                     rd_valid_s1;
	logic [ENTRY_W-1:0]       rd_idx_s1;
	logic                     hit_q;
	logic [ENTRY_W-1:0]       hit_idx_q;
	logic [CNT_W-1:0]         hit_cnt_q;
	logic                     free_q;
	logic [ENTRY_W-1:0]       free_idx_q;
	logic [SIDX_W-1:0]        slot_q;
	logic                     out_valid_q;
	result_t                  out_q;

	logic                     key_we;
	logic [ENTRY_W-1:0]       key_waddr;
	key_word_t                key_wdata;
	logic                     key_re;
	key_word_t                key_rdata;
	logic                     slot_we;
	logic [SLOT_AW-1:0]       slot_waddr;
	locator_t                 slot_wdata;
	logic                     slot_re;
	logic [SLOT_AW-1:0]       slot_raddr;
	locator_t                 slot_rdata;
	logic                     load;
	logic                     is_last;

	function automatic logic [SLOT_AW-1:0] slot_addr(input logic [ENTRY_W-1:0] e,
		input logic [SIDX_W-1:0] s);
		return SLOT_AW'(e) * SLOT_AW'(SLOTS_PER_ENTRY) + SLOT_AW'(s);
	endfunction

	ilmt_ram #(.DEPTH(TABLE_ENTRIES), .WIDTH(CNT_W + KEY_W)) u_key_ram (
		.clk   (clk),
		.we    (key_we),
		.waddr (key_waddr),
		.wdata (key_wdata),
		.re    (key_re),
		.raddr (scan_idx_q),
		.rdata (key_rdata)
	);

	ilmt_ram #(.DEPTH(SLOT_DEPTH), .WIDTH(2 * ADDR_W + PORT_W)) u_slot_ram (
		.clk   (clk),
		.we    (slot_we),
		.waddr (slot_waddr),
		.wdata (slot_wdata),
		.re    (slot_re),
		.raddr (slot_raddr),
		.rdata (slot_rdata)
	);

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign out_res   = out_q;
	assign key_re    = (state_q == ST_SCAN);
	assign slot_re   = (state_q == ST_RD);
	assign slot_raddr = slot_addr(hit_idx_q, slot_q);
	assign load      = (state_q == ST_LD) && (!out_valid_q || out_ready);
	assign is_last   = (slot_q == SIDX_W'(SLOTS_PER_ENTRY - 1));

	// table writes happen only in the decide cycle, after the whole scan,
	// so no read of this item can overlap a write
	always_comb begin
		key_we          = 1'b0;
		key_waddr       = free_idx_q;
		key_wdata.key   = item_q.key;
		key_wdata.count = CNT_W'(1);
		slot_we         = 1'b0;
		slot_waddr      = slot_addr(free_idx_q, '0);
		slot_wdata      = item_q.sender;
		if (state_q == ST_DECIDE && item_q.req_type == REQ_REGISTER) begin
			if (hit_q) begin
				if (hit_cnt_q < CNT_W'(SLOTS_PER_ENTRY)) begin
					key_we          = 1'b1;
					key_waddr       = hit_idx_q;
					key_wdata.count = hit_cnt_q + CNT_W'(1);
					slot_we         = 1'b1;
					slot_waddr      = slot_addr(hit_idx_q, SIDX_W'(hit_cnt_q));
				end
			end else if (free_q) begin
				key_we  = 1'b1;
				slot_we = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			item_q      <= '0;
			valid_q     <= '0;
			scan_idx_q  <= '0;
			rd_valid_s1 <= 1'b0;
			rd_idx_s1   <= '0;
			hit_q       <= 1'b0;
			hit_idx_q   <= '0;
			hit_cnt_q   <= '0;
			free_q      <= 1'b0;
			free_idx_q  <= '0;
			slot_q      <= '0;
			out_valid_q <= 1'b0;
			out_q       <= '0;
		end else begin
			rd_valid_s1 <= key_re;
			rd_idx_s1   <= scan_idx_q;

			// compare stage: key read issued last cycle
			if (rd_valid_s1) begin
				if (!hit_q && valid_q[rd_idx_s1] && key_rdata.key == item_q.key) begin
					hit_q     <= 1'b1;
					hit_idx_q <= rd_idx_s1;
					hit_cnt_q <= key_rdata.count;
				end
				if (!free_q && !valid_q[rd_idx_s1]) begin
					free_q     <= 1'b1;
					free_idx_q <= rd_idx_s1;
				end
			end

			if (load) begin
				out_valid_q           <= 1'b1;
				out_q.dest.addr_high  <= item_q.sender.addr_high;
				out_q.dest.addr_low   <= item_q.sender.addr_low;
				out_q.dest.port       <= reply_port;
				out_q.locator_count   <= hit_cnt_q;
				out_q.slot_index      <= slot_q;
				out_q.loc             <= (CNT_W'(slot_q) < hit_cnt_q) ? slot_rdata : '0;
				out_q.last            <= is_last;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						item_q     <= in_item;
						scan_idx_q <= '0;
						hit_q      <= 1'b0;
						free_q     <= 1'b0;
						state_q    <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (scan_idx_q == ENTRY_W'(TABLE_ENTRIES - 1)) begin
						state_q <= ST_DRAIN;
					end else begin
						scan_idx_q <= scan_idx_q + ENTRY_W'(1);
					end
				end
				ST_DRAIN: begin
					state_q <= ST_DECIDE;
				end
				ST_DECIDE: begin
					slot_q <= '0;
					if (item_q.req_type == REQ_REGISTER) begin
						if (!hit_q && free_q) begin
							valid_q[free_idx_q] <= 1'b1;
						end
						state_q <= ST_IDLE;
					end else if (hit_q) begin
						state_q <= ST_RD;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_RD: begin
					state_q <= ST_LD;
				end
				ST_LD: begin
					if (load) begin
						if (is_last) begin
							state_q <= ST_IDLE;
						end else begin
							slot_q  <= slot_q + SIDX_W'(1);
							state_q <= ST_RD;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("second word taken while an item is in flight");

	a_slot_wr_range: assert property (@(posedge clk) disable iff (!arst_n)
		slot_we |-> slot_waddr < SLOT_AW'(SLOT_DEPTH))
		else $error("locator write beyond table");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> out_q.locator_count != '0 &&
			out_q.locator_count <= CNT_W'(SLOTS_PER_ENTRY))
		else $error("reply with bad locator count");

	a_no_wr_on_emit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RD || state_q == ST_LD) |-> !key_we && !slot_we)
		else $error("table write during reply");

endmodule

// ===== rtl/core/id_locator_mapping_table.sv =====
// id_locator_mapping_table: top level, stream port packing and reply port register.
// Depends on ilmt_pkg and ilmt_ctrl.
//
// Exact-match table of 256 entries mapping a 160-bit identifier to up to three
// locators (IPv6 address and port). Each input word is handled alone: the
// 256 stored keys are read from one simple dual-port key RAM at one entry per cycle,
// so every word goes through accept, a 256-entry scan, a compare drain and a
// decide step. A lookup hit then reads the three locator slots from the slot RAM
// one after the other, one reply word per slot.
// A register word gives no reply; a lookup miss gives none either. Replies
// sit in an output register, so the next input word is taken while the last
// reply word still waits for m_tready. No clearing pass follows reset: entry
// valid bits live in flops and clear at once.
module id_locator_mapping_table
	import ilmt_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	// key_high, key_mid, key_low, sender_addr_high, sender_addr_low, sender_port
	input  logic [S_TDATA_W-1:0] s_tdata,
	// req_type
	input  logic                 s_tuser,
	output logic                 m_tvalid,
	input  logic                 m_tready,
	// dest_addr_high, dest_addr_low, dest_port, locator_count, slot_index,
	// loc_addr_high, loc_addr_low, loc_port, zero pad
	output logic [M_TDATA_W-1:0] m_tdata,
	output logic                 m_tlast,
	input  logic                 cfg_we,
	input  logic [PORT_W-1:0]    cfg_wdata
);

	logic [PORT_W-1:0] reply_port_q;
	item_t             in_item;
	result_t           out_res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reply_port_q <= REPLY_PORT_RST;
		end else if (cfg_we) begin
			reply_port_q <= cfg_wdata;
		end
	end

	assign in_item.req_type         = s_tuser;
	assign in_item.key              = {s_tdata[63:0], s_tdata[127:64], s_tdata[159:128]};
	assign in_item.sender.addr_high = s_tdata[223:160];
	assign in_item.sender.addr_low  = s_tdata[287:224];
	assign in_item.sender.port      = s_tdata[303:288];

	ilmt_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_tvalid),
		.in_ready   (s_tready),
		.in_item    (in_item),
		.reply_port (reply_port_q),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.out_res    (out_res)
	);

	assign m_tdata = {4'b0000,
		out_res.loc.port,
		out_res.loc.addr_low,
		out_res.loc.addr_high,
		out_res.slot_index,
		out_res.locator_count,
		out_res.dest.port,
		out_res.dest.addr_low,
		out_res.dest.addr_high};
	assign m_tlast = out_res.last;

endmodule

// ===== tb/id_locator_mapping_table_tb.sv =====
// id_locator_mapping_table_tb: self-checking bench for the identifier-to-locator table.
// Drives the word stream, tracks the table contents and checks every reply word.
// Depends on ilmt_pkg and id_locator_mapping_table.
`timescale 1ns / 100ps

module id_locator_mapping_table_tb;
	import ilmt_pkg::*;

	localparam int WORD_LATENCY   = 300;
	localparam int WATCHDOG_LIMIT = 6000;
	localparam int POOL_SIZE      = 8;

	typedef struct {
		item_t            it;
		bit               typed;
		logic [CNT_W-1:0] tcnt;   // 0: miss typed in
		locator_t         tloc0;
	} dir_row_t;

	localparam locator_t LOC_ONES = '{addr_high: '1, addr_low: '1, port: '1};
	localparam locator_t LOC_ZERO = '{addr_high: '0, addr_low: '0, port: '0};
	localparam locator_t LOC_A    = '{addr_high: 64'h0123_4567_89AB_CDEF,
		addr_low: 64'hFEDC_BA98_7654_3210, port: 16'h1234};
	localparam locator_t LOC_B    = '{addr_high: 64'h8000_0000_0000_0001,
		addr_low: 64'h7FFF_FFFF_FFFF_FFFE, port: 16'h8001};

	logic                 clk       = 1'b0;
	logic                 arst_n    = 1'b0;
	logic                 s_tvalid  = 1'b0;
	logic                 s_tready;
	logic [S_TDATA_W-1:0] s_tdata   = '0;
	logic                 s_tuser   = 1'b0;
	logic                 m_tvalid;
	logic                 m_tready  = 1'b0;
	logic [M_TDATA_W-1:0] m_tdata;
	logic                 m_tlast;
	logic                 cfg_we    = 1'b0;
	logic [PORT_W-1:0]    cfg_wdata = '0;

	// table image
	bit               tbl_valid [TABLE_ENTRIES];
	logic [KEY_W-1:0] tbl_key   [TABLE_ENTRIES];
	logic [CNT_W-1:0] tbl_cnt   [TABLE_ENTRIES];
	locator_t         tbl_loc   [TABLE_ENTRIES][SLOTS_PER_ENTRY];
	int               used = 0;
	logic [PORT_W-1:0] reply_port_q = REPLY_PORT_RST;

	result_t  pending_replies [$];
	dir_row_t dir_rows [$];
	logic [KEY_W-1:0] key_pool [POOL_SIZE];

	int err_cnt      = 0;
	int words_seen   = 0;
	int quiet_cycles = 0;
	int sink_stall   = 0;
	bit calm         = 1'b0;

	always #1 clk = ~clk;

	id_locator_mapping_table dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	task automatic flag_mismatch(input string what, input logic [63:0] got,
		input logic [63:0] want);
		err_cnt++;
		if (err_cnt <= 40)
			$display("mismatch %s at reply word %0d: got %h want %h", what, words_seen, got,
				want);
	endtask

	function automatic int find_key(input logic [KEY_W-1:0] k);
		for (int i = 0; i < TABLE_ENTRIES; i++)
			if (tbl_valid[i] && tbl_key[i] == k)
				return i;
		return -1;
	endfunction

	function automatic int find_free();
		for (int i = 0; i < TABLE_ENTRIES; i++)
			if (!tbl_valid[i])
				return i;
		return -1;
	endfunction

	// Apply one accepted word to the table image; queue its replies if asked.
	task automatic table_apply(input item_t it, input bit queue_it);
		int e;
		result_t r;
		e = find_key(it.key);
		if (it.req_type == REQ_REGISTER) begin
			if (e < 0) begin
				e = find_free();
				if (e >= 0) begin
					tbl_valid[e] = 1'b1;
					tbl_key[e] = it.key;
					tbl_cnt[e] = CNT_W'(1);
					tbl_loc[e][0] = it.sender;
					used++;
				end
			end else if (tbl_cnt[e] < SLOTS_PER_ENTRY) begin
				tbl_loc[e][tbl_cnt[e]] = it.sender;
				tbl_cnt[e] = tbl_cnt[e] + 1'b1;
			end
		end else if (e >= 0 && queue_it) begin
			for (int s = 0; s < SLOTS_PER_ENTRY; s++) begin
				r.dest.addr_high = it.sender.addr_high;
				r.dest.addr_low = it.sender.addr_low;
				r.dest.port = reply_port_q;
				r.locator_count = tbl_cnt[e];
				r.slot_index = SIDX_W'(s);
				r.loc = (s < tbl_cnt[e]) ? tbl_loc[e][s] : LOC_ZERO;
				r.last = (s == SLOTS_PER_ENTRY - 1);
				pending_replies.push_back(r);
			end
		end
	endtask

	function automatic item_t mk_item(input logic req, input logic [KEY_W-1:0] k,
		input locator_t l);
		item_t it;
		it.req_type = req;
		it.key = k;
		it.sender = l;
		return it;
	endfunction

	function automatic logic [KEY_W-1:0] rand_key();
		return {$urandom, $urandom, $urandom, $urandom, $urandom};
	endfunction

	function automatic locator_t rand_loc();
		locator_t l;
		int r;
		r = $urandom_range(0, 99);
		if (r < 3)
			return LOC_ONES;
		if (r < 6)
			return LOC_ZERO;
		l.addr_high = {$urandom, $urandom};
		l.addr_low = {$urandom, $urandom};
		l.port = PORT_W'($urandom_range(0, 65535));
		return l;
	endfunction

	function automatic int gap_len();
		int r;
		if (calm)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 70)
			return 0;
		if (r < 93)
			return $urandom_range(1, 3);
		return $urandom_range(10, 80);
	endfunction

	// Present one word and hold it until accepted; called on a rising edge.
	task automatic offer_word(input item_t it, input bit typed, input logic [CNT_W-1:0] tcnt,
		input locator_t tloc0);
		result_t r;
		s_tvalid <= 1'b1;
		s_tuser <= it.req_type;
		s_tdata <= {it.sender.port, it.sender.addr_low, it.sender.addr_high,
			it.key[31:0], it.key[95:32], it.key[159:96]};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		table_apply(it, !typed);
		if (typed && tcnt != 0) begin
			for (int s = 0; s < SLOTS_PER_ENTRY; s++) begin
				r.dest.addr_high = it.sender.addr_high;
				r.dest.addr_low = it.sender.addr_low;
				r.dest.port = REPLY_PORT_RST;
				r.locator_count = tcnt;
				r.slot_index = SIDX_W'(s);
				r.loc = (s == 0) ? tloc0 : LOC_ZERO;
				r.last = (s == SLOTS_PER_ENTRY - 1);
				pending_replies.push_back(r);
			end
		end
	endtask

	task automatic send_rand(input item_t it);
		int n;
		offer_word(it, 1'b0, '0, LOC_ZERO);
		if ($urandom_range(0, 39) == 0)
			calm <= ~calm;
		n = gap_len();
		if (n > 0) begin
			s_tvalid <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	task automatic wait_replies_done();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending_replies.size() != 0)
			@(posedge clk);
	endtask

	task automatic set_reply_port(input logic [PORT_W-1:0] v);
		wait_replies_done();
		// a register word leaves no reply to wait on
		repeat (WORD_LATENCY) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		reply_port_q = v;
	endtask

	task automatic add_row(input logic req, input logic [KEY_W-1:0] k, input locator_t l,
		input bit typed, input logic [CNT_W-1:0] tcnt, input locator_t tloc0);
		dir_row_t row;
		row.it = mk_item(req, k, l);
		row.typed = typed;
		row.tcnt = tcnt;
		row.tloc0 = tloc0;
		dir_rows.push_back(row);
	endtask

	task automatic run_pool_phase(input int n);
		int r;
		logic [KEY_W-1:0] k;
		for (int i = 0; i < n; i++) begin
			r = $urandom_range(0, 99);
			k = key_pool[$urandom_range(0, POOL_SIZE - 1)];
			if (r < 45)
				send_rand(mk_item(REQ_REGISTER, k, rand_loc()));
			else if (r < 85)
				send_rand(mk_item(REQ_LOOKUP, k, rand_loc()));
			else if (r < 95)
				send_rand(mk_item(REQ_LOOKUP, rand_key(), rand_loc()));
			else
				send_rand(mk_item(REQ_REGISTER, rand_key(), rand_loc()));
			if ($urandom_range(0, 49) == 0)
				wait_replies_done();
		end
	endtask

	// Fill the table, then keep going past full with dropped keys.
	task automatic run_fill_phase();
		int r;
		int tail;
		logic [KEY_W-1:0] dropped;
		tail = 0;
		dropped = rand_key();
		while (used < TABLE_ENTRIES || tail < 30) begin
			r = $urandom_range(0, 99);
			if (used < TABLE_ENTRIES) begin
				if (r < 85)
					send_rand(mk_item(REQ_REGISTER, rand_key(), rand_loc()));
				else if (r < 95)
					send_rand(mk_item(REQ_LOOKUP, tbl_key[$urandom_range(0, used - 1)],
						rand_loc()));
				else
					send_rand(mk_item(REQ_REGISTER, tbl_key[$urandom_range(0, used - 1)],
						rand_loc()));
			end else begin
				tail++;
				if (r < 35) begin
					dropped = rand_key();
					send_rand(mk_item(REQ_REGISTER, dropped, rand_loc()));
				end else if (r < 55)
					send_rand(mk_item(REQ_LOOKUP, dropped, rand_loc()));
				else if (r < 85)
					send_rand(mk_item(REQ_LOOKUP, tbl_key[$urandom_range(0, used - 1)],
						rand_loc()));
				else
					send_rand(mk_item(REQ_REGISTER, tbl_key[$urandom_range(0, used - 1)],
						rand_loc()));
			end
			if ($urandom_range(0, 99) == 0)
				wait_replies_done();
		end
	endtask

	always @(posedge clk) begin : sink_pace
		int r;
		if (sink_stall != 0) begin
			sink_stall <= sink_stall - 1;
			m_tready <= (sink_stall == 1);
		end else if (!calm && $urandom_range(0, 99) < 10) begin
			r = $urandom_range(0, 99);
			sink_stall <= (r < 85) ? $urandom_range(1, 3) : $urandom_range(10, 80);
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	always @(posedge clk) begin : reply_check
		result_t got;
		result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			words_seen++;
			if (pending_replies.size() == 0) begin
				flag_mismatch("word with no reply pending", m_tdata[63:0], '0);
			end else begin
				want = pending_replies.pop_front();
				got.dest.addr_high = m_tdata[63:0];
				got.dest.addr_low = m_tdata[127:64];
				got.dest.port = m_tdata[143:128];
				got.locator_count = m_tdata[145:144];
				got.slot_index = m_tdata[147:146];
				got.loc.addr_high = m_tdata[211:148];
				got.loc.addr_low = m_tdata[275:212];
				got.loc.port = m_tdata[291:276];
				got.last = m_tlast;
				if (got.dest.addr_high !== want.dest.addr_high)
					flag_mismatch("dest_addr_high", got.dest.addr_high, want.dest.addr_high);
				if (got.dest.addr_low !== want.dest.addr_low)
					flag_mismatch("dest_addr_low", got.dest.addr_low, want.dest.addr_low);
				if (got.dest.port !== want.dest.port)
					flag_mismatch("dest_port", 64'(got.dest.port), 64'(want.dest.port));
				if (got.locator_count !== want.locator_count)
					flag_mismatch("locator_count", 64'(got.locator_count),
						64'(want.locator_count));
				if (got.slot_index !== want.slot_index)
					flag_mismatch("slot_index", 64'(got.slot_index), 64'(want.slot_index));
				if (got.loc.addr_high !== want.loc.addr_high)
					flag_mismatch("loc_addr_high", got.loc.addr_high, want.loc.addr_high);
				if (got.loc.addr_low !== want.loc.addr_low)
					flag_mismatch("loc_addr_low", got.loc.addr_low, want.loc.addr_low);
				if (got.loc.port !== want.loc.port)
					flag_mismatch("loc_port", 64'(got.loc.port), 64'(want.loc.port));
				if (got.last !== want.last)
					flag_mismatch("last", 64'(got.last), 64'(want.last));
				if (m_tdata[295:292] !== 4'b0)
					flag_mismatch("pad", 64'(m_tdata[295:292]), '0);
			end
		end
	end

	// counts cycles with no word moving on either side
	always @(posedge clk) begin : watchdog
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("timeout after %0d quiet cycles", quiet_cycles);
				$display("TB_ERROR");
				$finish;
			end
		end
	end

	initial begin
		logic [KEY_W-1:0] base;

		// reply port still at reset value for the whole table below
		add_row(REQ_LOOKUP,   '0, LOC_A,    1'b1, 2'd0, LOC_ZERO);  // empty table
		add_row(REQ_REGISTER, '0, LOC_ONES, 1'b0, 2'd0, LOC_ZERO);
		add_row(REQ_LOOKUP,   '0, LOC_ZERO, 1'b1, 2'd1, LOC_ONES);
		add_row(REQ_REGISTER, '1, LOC_ZERO, 1'b0, 2'd0, LOC_ZERO);
		add_row(REQ_LOOKUP,   '1, LOC_ONES, 1'b1, 2'd1, LOC_ZERO);
		// keys one part away from all-ones must miss
		add_row(REQ_LOOKUP, {64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 32'h0},
			LOC_A, 1'b1, 2'd0, LOC_ZERO);
		add_row(REQ_LOOKUP, {64'hFFFF_FFFF_FFFF_FFFF, 64'h0, 32'hFFFF_FFFF},
			LOC_A, 1'b1, 2'd0, LOC_ZERO);
		add_row(REQ_LOOKUP, {64'h0, 64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF},
			LOC_A, 1'b1, 2'd0, LOC_ZERO);
		add_row(REQ_REGISTER, '0, LOC_A,    1'b0, 2'd0, LOC_ZERO);
		add_row(REQ_REGISTER, '0, LOC_A,    1'b0, 2'd0, LOC_ZERO);  // duplicate kept
		add_row(REQ_REGISTER, '0, LOC_B,    1'b0, 2'd0, LOC_ZERO);  // entry full
		add_row(REQ_LOOKUP,   '0, LOC_B,    1'b0, 2'd0, LOC_ZERO);
		add_row(REQ_REGISTER, '1, LOC_B,    1'b0, 2'd0, LOC_ZERO);
		add_row(REQ_LOOKUP,   '1, LOC_A,    1'b0, 2'd0, LOC_ZERO);  // one unused slot
		add_row(REQ_REGISTER, {5{32'hA5C3_5A3C}}, LOC_A, 1'b0, 2'd0, LOC_ZERO);
		add_row(REQ_LOOKUP,   {5{32'hA5C3_5A3C}}, LOC_ZERO, 1'b1, 2'd1, LOC_A);
		add_row(REQ_LOOKUP,   '0, LOC_ONES, 1'b0, 2'd0, LOC_ZERO);

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i]) begin
			offer_word(dir_rows[i].it, dir_rows[i].typed, dir_rows[i].tcnt,
				dir_rows[i].tloc0);
			if (i % 4 == 3) begin
				s_tvalid <= 1'b0;
				repeat ($urandom_range(1, 20)) @(posedge clk);
			end
		end

		// pool keys: near neighbours in each key part, plus unrelated ones
		base = rand_key();
		key_pool[0] = base;
		key_pool[1] = base ^ {{$urandom, $urandom} | 64'h1, 96'h0};
		key_pool[2] = base ^ {64'h0, {$urandom, $urandom} | 64'h1, 32'h0};
		key_pool[3] = base ^ (KEY_W'(1) << $urandom_range(0, 31));
		for (int i = 4; i < POOL_SIZE; i++)
			key_pool[i] = rand_key();

		set_reply_port('0);
		run_pool_phase(40);
		set_reply_port('1);
		run_pool_phase(40);
		set_reply_port(PORT_W'($urandom_range(0, 65535)));
		run_fill_phase();

		wait_replies_done();
		repeat (WORD_LATENCY) @(posedge clk);
		if (pending_replies.size() != 0)
			flag_mismatch("replies never arrived", 64'(pending_replies.size()), '0);
		if (err_cnt == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/core/ilmt_pkg.sv
rtl/core/ilmt_ram.sv
rtl/core/ilmt_ctrl.sv
rtl/core/id_locator_mapping_table.sv
tb/id_locator_mapping_table_tb.sv
